// ===== rtl/aals_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-aliased line stepper package
// Shared codes, sequencer states and status types for the line stepper.
// ----------------------------------------------------------------------------
package aals_pkg;

  // Command codes carried on the request channel
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Pixel coverage levels
  localparam int         LEVEL_BITS = 8;
  localparam logic [7:0] FULL_LEVEL = 8'd255;
  localparam logic [7:0] HALF_LEVEL = 8'd127;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORDER,
    ST_DIV,
    ST_FIRST,
    ST_MAIN,
    ST_BELOW,
    ST_FINAL
  } aals_state_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/aals_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line command channel
// Valid/ready channel carrying start and step requests with endpoints.
// ----------------------------------------------------------------------------
interface aals_cmd_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_finish;
  logic [COORD_BITS-1:0] y_finish;

  modport source (
    output valid, command, x_start, y_start, x_finish, y_finish,
    input  ready
  );

  modport sink (
    input  valid, command, x_start, y_start, x_finish, y_finish,
    output ready
  );
endinterface

// ===== rtl/aals_pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one shaded pixel per request.
// ----------------------------------------------------------------------------
interface aals_pix_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [7:0]            intensity;
  logic                  last;

  modport source (
    output valid, pixel_x, pixel_y, intensity, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, intensity, last,
    output ready
  );
endinterface

// ===== rtl/aals_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient divider
// Restoring divider, one quotient bit per cycle, for the line gradient.
// ----------------------------------------------------------------------------
module aals_divider #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [COORD_BITS+FRAC_BITS-1:0] dividend,
  input  logic [COORD_BITS-1:0]           divisor,
  output logic [COORD_BITS+FRAC_BITS-1:0] quotient,
  output aals_pkg::div_stat_t             stat
);
  import aals_pkg::*;

  localparam int DIV_BITS = COORD_BITS + FRAC_BITS;
  localparam int CNT_BITS = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0]   work;
  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] dsor;
  logic [CNT_BITS-1:0]   cnt;
  logic                  busy;
  logic                  done;

  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, work[DIV_BITS-1]};
    diff  = trial - {1'b0, dsor};
    fits  = trial >= {1'b0, dsor};
  end

  // Iterate: quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIV_BITS);
        work <= dividend;
        rem  <= '0;
        dsor <= divisor;
      end else if (busy) begin
        work <= {work[DIV_BITS-2:0], fits};
        rem  <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = work;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/aals_shade.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage shader
// Turns the row fraction into the levels of the main pixel and the one below.
// ----------------------------------------------------------------------------
module aals_shade #(
  parameter int FRAC_BITS = 16
) (
  input  logic [FRAC_BITS-1:0] frac,
  output logic [7:0]           main_level,
  output logic [7:0]           below_level
);
  import aals_pkg::*;

  logic [FRAC_BITS:0]   inv;
  logic [FRAC_BITS+8:0] main_prod;
  logic [FRAC_BITS+7:0] below_prod;

  // Scale by 255 as a shift and subtract, keep the integer part
  always_comb begin
    inv         = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    main_prod   = {inv, 8'd0} - {8'd0, inv};
    below_prod  = {frac, 8'd0} - {8'd0, frac};
    main_level  = main_prod[FRAC_BITS+LEVEL_BITS-1:FRAC_BITS];
    below_level = below_prod[FRAC_BITS+LEVEL_BITS-1:FRAC_BITS];
  end

endmodule

// ===== rtl/antialiased_line_stepper_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-aliased line stepper
// Wu line rasterizer: a start request sets up a line, each step request
// emits the pixels of the next column with their coverage.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                   | Per request
//  cmd     | in  | command, x_start, y_start, x_finish, y_f. | start or step
//  pix     | out | pixel_x, pixel_y, intensity, last         | one pixel
//
//  Start: orders the endpoints, then the restoring divider produces one
//  gradient bit per cycle; a single-point line skips the divider.
//  Inner step: two pixels (main row, then the row below) through the
//  output register; end column: one pixel; step while idle: no pixel.
//  cmd.ready is low until the sequencer returns to idle.
//  A stalled pix channel holds the sequencer in its emit state.
//  Reset (rst, synchronous) clears the sequencer and drops any line.
// ----------------------------------------------------------------------------
module antialiased_line_stepper_unit #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  aals_cmd_if.sink   cmd,
  aals_pix_if.source pix
);
  import aals_pkg::*;

  localparam int SLOPE_BITS = FRAC_BITS + 2;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
  localparam logic signed [SLOPE_BITS-1:0] SLOPE_ONE =
    SLOPE_BITS'(1) << FRAC_BITS;

  aals_state_t state, state_next;

  // Line state
  logic                  active;
  logic                  steep_flag;
  logic [COORD_BITS-1:0] major_pos;
  logic [COORD_BITS-1:0] major_stop;
  logic [COORD_BITS-1:0] minor_end;
  logic [ACC_BITS-1:0]   row_accum;
  logic [SLOPE_BITS-1:0] slope;

  // Setup registers
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic                  neg;
  logic                  span_zero;

  // Output register
  logic out_valid;
  logic out_load;
  logic cmd_acc;

  // Request-side helpers
  logic [COORD_BITS-1:0] adx, ady;
  logic                  steep_in;

  // Ordering helpers
  logic                  swap;
  logic [COORD_BITS-1:0] p0x, p0y, p1x, p1y, dx, mag;
  logic                  neg_in;

  // Divider
  logic                  div_start;
  logic [ACC_BITS-1:0]   div_quo;
  div_stat_t             div_stat;
  logic [SLOPE_BITS-1:0] q_trunc;

  // Shading and emit selection
  logic [COORD_BITS-1:0] row;
  logic [7:0]            main_level, below_level;
  logic [ACC_BITS-1:0]   slope_ext;
  logic                  emit;
  logic [COORD_BITS-1:0] e_major, e_minor;
  logic [7:0]            e_level;
  logic                  e_last;

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign out_load  = !out_valid || pix.ready;
  assign pix.valid = out_valid;

  // Span magnitudes of the raw endpoints
  always_comb begin
    adx      = (cmd.x_start > cmd.x_finish) ? cmd.x_start - cmd.x_finish
                                            : cmd.x_finish - cmd.x_start;
    ady      = (cmd.y_start > cmd.y_finish) ? cmd.y_start - cmd.y_finish
                                            : cmd.y_finish - cmd.y_start;
    steep_in = ady > adx;
  end

  // Order endpoints by major coordinate and take the spans
  always_comb begin
    swap   = ax > bx;
    p0x    = swap ? bx : ax;
    p0y    = swap ? by : ay;
    p1x    = swap ? ax : bx;
    p1y    = swap ? ay : by;
    dx     = p1x - p0x;
    neg_in = p1y < p0y;
    mag    = neg_in ? p0y - p1y : p1y - p0y;
  end

  assign div_start = (state == ST_ORDER) && (dx != '0);
  assign q_trunc   = div_quo[SLOPE_BITS-1:0];

  aals_divider #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag, {FRAC_BITS{1'b0}}}),
    .divisor  (dx),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign row       = row_accum[ACC_BITS-1:FRAC_BITS];
  assign slope_ext = {{(ACC_BITS-SLOPE_BITS){slope[SLOPE_BITS-1]}}, slope};

  aals_shade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shade (
    .frac        (row_accum[FRAC_BITS-1:0]),
    .main_level  (main_level),
    .below_level (below_level)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and emit selection
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    e_major    = major_pos;
    e_minor    = row;
    e_level    = HALF_LEVEL;
    e_last     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_acc) begin
          if (cmd.command == CMD_START) begin
            state_next = ST_ORDER;
          end else if (active) begin
            state_next = (major_pos == major_stop) ? ST_FINAL : ST_MAIN;
          end
        end
      end
      ST_ORDER: begin
        state_next = (dx == '0) ? ST_FIRST : ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        emit    = 1'b1;
        e_major = ax;
        e_minor = ay;
        e_level = HALF_LEVEL;
        e_last  = span_zero;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      ST_MAIN: begin
        emit    = 1'b1;
        e_level = main_level;
        if (out_load) begin
          state_next = ST_BELOW;
        end
      end
      ST_BELOW: begin
        emit    = 1'b1;
        e_minor = row + 1'b1;
        e_level = below_level;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      ST_FINAL: begin
        emit    = 1'b1;
        e_major = major_stop;
        e_minor = minor_end;
        e_level = HALF_LEVEL;
        e_last  = 1'b1;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Setup and line state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      steep_flag <= 1'b0;
      major_pos  <= '0;
      major_stop <= '0;
      minor_end  <= '0;
      row_accum  <= '0;
      slope      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_acc && cmd.command == CMD_START) begin
            steep_flag <= steep_in;
            ax <= steep_in ? cmd.y_start  : cmd.x_start;
            ay <= steep_in ? cmd.x_start  : cmd.y_start;
            bx <= steep_in ? cmd.y_finish : cmd.x_finish;
            by <= steep_in ? cmd.x_finish : cmd.y_finish;
          end
        end
        ST_ORDER: begin
          ax        <= p0x;
          ay        <= p0y;
          bx        <= p1x;
          by        <= p1y;
          neg       <= neg_in;
          span_zero <= (dx == '0);
          if (dx == '0) begin
            slope <= '0;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            slope <= neg ? SLOPE_BITS'(0) - q_trunc : q_trunc;
          end
        end
        ST_FIRST: begin
          if (out_load) begin
            major_stop <= bx;
            minor_end  <= by;
            active     <= !span_zero;
            major_pos  <= span_zero ? ax : ax + 1'b1;
            row_accum  <= {ay, {FRAC_BITS{1'b0}}} + slope_ext;
          end
        end
        ST_MAIN: begin
        end
        ST_BELOW: begin
          if (out_load) begin
            row_accum <= row_accum + slope_ext;
            major_pos <= major_pos + 1'b1;
          end
        end
        ST_FINAL: begin
          if (out_load) begin
            active <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Load the output register, drop valid once the pixel is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && out_load) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_load) begin
      pix.pixel_x   <= steep_flag ? e_minor : e_major;
      pix.pixel_y   <= steep_flag ? e_major : e_minor;
      pix.intensity <= e_level;
      pix.last      <= e_last;
    end
  end

  // The divider only runs while a start request is being set up
  assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !div_stat.busy)
    else $error("divider busy while taking requests");

  // The final column ends the line
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL && out_load) |=> !active)
    else $error("line still active after final column");

  // The column counter never passes the last column
  assert property (@(posedge clk) disable iff (rst)
    active |-> (major_pos <= major_stop))
    else $error("column beyond end of line");

  // Gradient magnitude stays within one
  assert property (@(posedge clk) disable iff (rst)
    active |-> ($signed(slope) <= SLOPE_ONE && $signed(slope) >= -SLOPE_ONE))
    else $error("gradient out of range");

endmodule

// ===== tb/sv/tb_antialiased_line_stepper_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line stepper testbench
// Drives start and step requests into the anti-aliased line stepper and
// checks every emitted pixel against a cycle-free predictor of the Wu line
// walk. Both channels idle in random bursts, and the pixel side holds off
// once for a long stretch so that the command side backs up.
// ----------------------------------------------------------------------------
module tb_antialiased_line_stepper_unit;
  import aals_pkg::*;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_W      = COORD_BITS + FRAC_BITS;
  localparam int SLOPE_W    = FRAC_BITS + 2;
  localparam int unsigned FRAC_ONE = 1 << FRAC_BITS;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

  localparam int ITEMS        = 450;
  localparam int CALM_ITEMS   = 60;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic                  command;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_finish;
    logic [COORD_BITS-1:0] y_finish;
  } line_req_t;

  typedef struct {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [7:0]            intensity;
    logic                  last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aals_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_ch ();
  aals_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

  antialiased_line_stepper_unit #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .pix(pix_ch)
  );

  // Free-running clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pending requests and predicted pixels
  line_req_t req_q[$];
  pixel_t    expected_pixels[$];

  // Predicted line state
  logic                  ln_active;
  logic                  ln_steep;
  logic [COORD_BITS-1:0] ln_col;
  logic [COORD_BITS-1:0] ln_col_stop;
  logic [COORD_BITS-1:0] ln_row_stop;
  logic [ACC_W-1:0]      ln_acc;
  logic [SLOPE_W-1:0]    ln_grad;

  // Run bookkeeping
  int  n_total;
  int  n_reqs;
  int  n_starts;
  int  n_steps;
  int  n_idle_steps;
  int  n_pixels;
  int  n_fail;
  bit  req_taken;
  bit  holding;
  bit  calm;
  bit  hold_long;
  bit  send_burst = 1'b1;
  bit  recv_burst = 1'b1;
  int  send_gap;
  int  stall_left;
  line_req_t cur;

  // Push one pixel, swapping axes back for steep lines
  function automatic void emit_pixel(input logic [COORD_BITS-1:0] major,
                                     input logic [COORD_BITS-1:0] minor,
                                     input logic [7:0] level, input logic last);
    pixel_t p;
    p.pixel_x   = ln_steep ? minor : major;
    p.pixel_y   = ln_steep ? major : minor;
    p.intensity = level;
    p.last      = last;
    expected_pixels.push_back(p);
  endfunction

  // Advance the predicted line walk by one accepted request
  function automatic void trace_request(input line_req_t req);
    int ax, ay, bx, by, t, dx, dy, adx, ady;
    longint grad_q;
    logic [ACC_W-1:0]      grad_ext;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] row_below;
    int unsigned fr;
    int unsigned main_level;
    int unsigned below_level;
    if (req.command == CMD_START) begin
      n_starts++;
      ax  = int'(req.x_start);
      ay  = int'(req.y_start);
      bx  = int'(req.x_finish);
      by  = int'(req.y_finish);
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? by - ay : ay - by;
      ln_steep = (ady > adx);
      // walk along the longer axis, left to right
      if (ln_steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = by - ay;
      // gradient truncated toward zero, zero for a single point
      if (dx == 0) begin
        grad_q = 0;
      end else begin
        grad_q = (longint'(dy < 0 ? -dy : dy) << FRAC_BITS) / dx;
        if (dy < 0) grad_q = -grad_q;
      end
      ln_grad     = grad_q[SLOPE_W-1:0];
      grad_ext    = {{(ACC_W-SLOPE_W){ln_grad[SLOPE_W-1]}}, ln_grad};
      ln_col_stop = COORD_BITS'(bx);
      ln_row_stop = COORD_BITS'(by);
      emit_pixel(COORD_BITS'(ax), COORD_BITS'(ay), HALF_LEVEL, dx == 0);
      if (dx == 0) begin
        ln_active = 1'b0;
        ln_col    = COORD_BITS'(ax);
        ln_acc    = {COORD_BITS'(ay), {FRAC_BITS{1'b0}}};
      end else begin
        ln_active = 1'b1;
        ln_col    = COORD_BITS'(ax + 1);
        ln_acc    = {COORD_BITS'(ay), {FRAC_BITS{1'b0}}} + grad_ext;
      end
    end else if (!ln_active) begin
      n_idle_steps++;
    end else if (ln_col == ln_col_stop) begin
      n_steps++;
      emit_pixel(ln_col_stop, ln_row_stop, HALF_LEVEL, 1'b1);
      ln_active = 1'b0;
    end else begin
      n_steps++;
      // split coverage between the row and the one below
      row         = ln_acc[ACC_W-1:FRAC_BITS];
      row_below   = row + 1'b1;
      fr          = 32'(ln_acc[FRAC_BITS-1:0]);
      main_level  = ((FRAC_ONE - fr) * FULL_LEVEL) >> FRAC_BITS;
      below_level = (fr * FULL_LEVEL) >> FRAC_BITS;
      emit_pixel(ln_col, row, main_level[7:0], 1'b0);
      emit_pixel(ln_col, row_below, below_level[7:0], 1'b0);
      grad_ext = {{(ACC_W-SLOPE_W){ln_grad[SLOPE_W-1]}}, ln_grad};
      ln_acc   = ln_acc + grad_ext;
      ln_col   = ln_col + 1'b1;
    end
  endfunction

  // Compare one accepted pixel with the oldest prediction
  function automatic void check_pixel();
    pixel_t want;
    n_pixels++;
    if (expected_pixels.size() == 0) begin
      n_fail++;
      $error("unexpected pixel x=%0d y=%0d intensity=%0d last=%0d",
             pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.intensity, pix_ch.last);
      return;
    end
    want = expected_pixels.pop_front();
    if (pix_ch.pixel_x !== want.pixel_x) begin
      n_fail++;
      $error("pixel_x: expected %0d, got %0d", want.pixel_x, pix_ch.pixel_x);
    end
    if (pix_ch.pixel_y !== want.pixel_y) begin
      n_fail++;
      $error("pixel_y: expected %0d, got %0d", want.pixel_y, pix_ch.pixel_y);
    end
    if (pix_ch.intensity !== want.intensity) begin
      n_fail++;
      $error("intensity: expected %0d, got %0d", want.intensity, pix_ch.intensity);
    end
    if (pix_ch.last !== want.last) begin
      n_fail++;
      $error("last: expected %0d, got %0d", want.last, pix_ch.last);
    end
  endfunction

  // Stimulus helpers
  function automatic void push_req(input logic command,
                                   input int xs, input int ys,
                                   input int xf, input int yf);
    line_req_t r;
    r.command  = command;
    r.x_start  = COORD_BITS'(xs);
    r.y_start  = COORD_BITS'(ys);
    r.x_finish = COORD_BITS'(xf);
    r.y_finish = COORD_BITS'(yf);
    req_q.push_back(r);
  endfunction

  // Step payload is ignored by the block; fill it with noise
  function automatic void push_step();
    push_req(CMD_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
             $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endfunction

  function automatic void push_line(input int xs, input int ys, input int xf,
                                    input int yf, input int n_cols);
    push_req(CMD_START, xs, ys, xf, yf);
    for (int i = 0; i < n_cols; i++) push_step();
  endfunction

  function automatic int major_span(input int xs, input int ys, input int xf,
                                    input int yf);
    int adx, ady;
    adx = (xf > xs) ? xf - xs : xs - xf;
    ady = (yf > ys) ? yf - ys : ys - yf;
    return (adx > ady) ? adx : ady;
  endfunction

  function automatic int near(input int base, input int reach);
    int v;
    v = base + $urandom_range(0, 2 * reach) - reach;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // Accept requests, predict, and check pixels at the rising edge
  always @(posedge clk) begin
    line_req_t seen;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        seen.command  = cmd_ch.command;
        seen.x_start  = cmd_ch.x_start;
        seen.y_start  = cmd_ch.y_start;
        seen.x_finish = cmd_ch.x_finish;
        seen.y_finish = cmd_ch.y_finish;
        trace_request(seen);
        req_taken = 1'b1;
        n_reqs++;
        calm = (n_reqs >= n_total - CALM_ITEMS);
      end
      if (pix_ch.valid && pix_ch.ready) check_pixel();
    end
  end

  // Request driver: hold each request until taken, idle in bursts
  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken) begin
        req_taken = 1'b0;
        holding   = 1'b0;
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_q.size() > 0) begin
          if (!calm && !hold_long && send_burst && $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(1, 14);
          end else begin
            cur     = req_q.pop_front();
            holding = 1'b1;
            if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
          end
        end
      end
      cmd_ch.valid    <= holding;
      cmd_ch.command  <= cur.command;
      cmd_ch.x_start  <= cur.x_start;
      cmd_ch.y_start  <= cur.y_start;
      cmd_ch.x_finish <= cur.x_finish;
      cmd_ch.y_finish <= cur.y_finish;
    end
  end

  // Pixel receiver: stall in bursts, or for the long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && recv_burst && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      pix_ch.ready <= !(stall_left > 0 || hold_long);
    end
  end

  // Long hold-off on the pixel side while requests keep coming
  initial begin
    while (n_reqs < HOLD_AT) @(negedge clk);
    @(posedge clk);
    hold_long = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_long = 1'b0;
  end

  // Build the request list, release reset, wait for the drain
  initial begin
    int xs, ys, xf, yf, span, pick;
    cmd_ch.valid    = 1'b0;
    cmd_ch.command  = CMD_START;
    cmd_ch.x_start  = '0;
    cmd_ch.y_start  = '0;
    cmd_ch.x_finish = '0;
    cmd_ch.y_finish = '0;
    pix_ch.ready    = 1'b0;
    cur = '{CMD_START, '0, '0, '0, '0};

    // predictor starts from the cleared line state
    ln_active   = 1'b0;
    ln_steep    = 1'b0;
    ln_col      = '0;
    ln_col_stop = '0;
    ln_row_stop = '0;
    ln_acc      = '0;
    ln_grad     = '0;

    // step while idle, then a full-range diagonal abandoned by a new start
    push_step();
    push_line(0, 0, COORD_MAX, COORD_MAX, 2);
    // single point at the far corner, then an idle step
    push_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    push_step();
    // steep line, walked to its end
    push_line(5, 3, 7, 10, 7);
    // falling shallow line given right to left, near the top row
    push_line(20, COORD_MAX - 3, 14, COORD_MAX, 6);
    // flat line on the top row: the row below wraps with zero coverage
    push_line(0, COORD_MAX, 3, COORD_MAX, 3);

    // one long line
    xs = $urandom_range(0, 800);
    ys = $urandom_range(0, COORD_MAX);
    xf = xs + $urandom_range(100, 200);
    yf = near(ys, 150);
    push_line(xs, ys, xf, yf, major_span(xs, ys, xf, yf));

    // mostly short complete lines, some cut short, some noise
    while (req_q.size() < ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        push_req($urandom_range(0, 1) ? CMD_STEP : CMD_START,
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end else begin
        xs   = $urandom_range(0, COORD_MAX);
        ys   = $urandom_range(0, COORD_MAX);
        span = $urandom_range(0, 12);
        xf   = near(xs, span);
        yf   = near(ys, span);
        span = major_span(xs, ys, xf, yf);
        if (pick < 4) begin
          push_line(xs, ys, xf, yf, $urandom_range(0, span));
        end else begin
          push_line(xs, ys, xf, yf,
                    span + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0));
        end
      end
    end
    n_total = req_q.size();

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || holding) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d line starts, %0d column steps, %0d steps on no line.",
             n_reqs, n_starts, n_steps, n_idle_steps);
    $display("Checked %0d pixels, %0d field mismatches or stray pixels.", n_pixels, n_fail);
    if (n_fail == 0 && expected_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/aals_pkg.sv
rtl/aals_cmd_if.sv
rtl/aals_pix_if.sv
rtl/aals_divider.sv
rtl/aals_shade.sv
rtl/antialiased_line_stepper_unit.sv
tb/sv/tb_antialiased_line_stepper_unit.sv
